/* hw/rtl/jsu_pkg.sv */
// Shared types and constants of the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  typedef enum logic [1:0] {
    KindByte  = 2'd0,
    KindEnd   = 2'd1,
    KindError = 2'd2
  } kind_e;

  localparam logic [7:0] ChQuote     = 8'h22;
  localparam logic [7:0] ChBackslash = 8'h5C;
  localparam logic [7:0] ChSlash     = 8'h2F;
  localparam logic [7:0] ChLowerU    = 8'h75;

  localparam logic [7:0]  Utf8Cont   = 8'h80;
  localparam logic [7:0]  Utf8Lead2  = 8'hC0;
  localparam logic [7:0]  Utf8Lead3  = 8'hE0;
  localparam logic [15:0] Utf8Lim1   = 16'h0080;
  localparam logic [15:0] Utf8Lim2   = 16'h0800;
  localparam logic [5:0]  Utf8Mask   = 6'h3F;

  // Results of one input word: the first may be any kind, the others are bytes.
  typedef struct packed {
    logic [1:0] cnt;
    kind_e      kind;
    logic [7:0] byte0;
    logic [7:0] byte1;
    logic [7:0] byte2;
  } res_t;

endpackage

/* hw/rtl/jsu_if.sv */
// Handshake interfaces for the input and result channels of the unescaper.
`timescale 1ns / 1ps

interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_mark;

  modport source (output valid, in_byte, end_mark, input ready);
  modport sink   (input valid, in_byte, end_mark, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic       last;

  modport source (output valid, out_byte, kind, last, input ready);
  modport sink   (input valid, out_byte, kind, last, output ready);
endinterface

/* hw/rtl/jsu_decode.sv */
// Escape decoder that holds the parse phase and code point and yields up to three results.
`timescale 1ns / 1ps

module jsu_decode
  import jsu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] in_byte_i,
  input  logic       end_mark_i,
  output res_t       res_o
);

  typedef enum logic [2:0] {
    PhAwait = 3'd0,
    PhBody  = 3'd1,
    PhEsc   = 3'd2,
    PhHex1  = 3'd3,
    PhHex2  = 3'd4,
    PhHex3  = 3'd5,
    PhHex4  = 3'd6
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [15:0] cp_q, cp_d;

  logic        hex_ok;
  logic [3:0]  hex_val;
  logic [15:0] cp_next;
  logic        esc_ok;
  logic [7:0]  esc_byte;

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    priority if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_val = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_val = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_val = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign cp_next = {cp_q[11:0], hex_val};

  always_comb begin
    esc_ok   = 1'b1;
    esc_byte = 8'h00;
    unique case (in_byte_i)
      ChQuote:     esc_byte = ChQuote;
      ChBackslash: esc_byte = ChBackslash;
      ChSlash:     esc_byte = ChSlash;
      8'h6E:       esc_byte = 8'h0A;
      8'h72:       esc_byte = 8'h0D;
      8'h74:       esc_byte = 8'h09;
      8'h62:       esc_byte = 8'h08;
      8'h66:       esc_byte = 8'h0C;
      default:     esc_ok   = 1'b0;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    cp_d    = cp_q;
    res_o   = '{cnt: 2'd0, kind: KindByte, byte0: 8'h00, byte1: 8'h00, byte2: 8'h00};

    unique case (phase_q)
      PhBody, PhEsc, PhHex1, PhHex2, PhHex3, PhHex4: begin
        if (end_mark_i) begin
          res_o.cnt  = 2'd1;
          res_o.kind = KindError;
          phase_d    = PhAwait;
        end else if (phase_q == PhBody) begin
          if (in_byte_i == ChQuote) begin
            res_o.cnt  = 2'd1;
            res_o.kind = KindEnd;
            phase_d    = PhAwait;
          end else if (in_byte_i == ChBackslash) begin
            phase_d = PhEsc;
          end else begin
            res_o.cnt   = 2'd1;
            res_o.byte0 = in_byte_i;
          end
        end else if (phase_q == PhEsc) begin
          if (in_byte_i == ChLowerU) begin
            cp_d    = 16'h0000;
            phase_d = PhHex1;
          end else if (esc_ok) begin
            res_o.cnt   = 2'd1;
            res_o.byte0 = esc_byte;
            phase_d     = PhBody;
          end else begin
            res_o.cnt  = 2'd1;
            res_o.kind = KindError;
            phase_d    = PhAwait;
          end
        end else if (!hex_ok) begin
          res_o.cnt  = 2'd1;
          res_o.kind = KindError;
          phase_d    = PhAwait;
        end else begin
          cp_d = cp_next;
          if (phase_q != PhHex4) begin
            phase_d = phase_e'(phase_q + 3'd1);
          end else begin
            phase_d = PhBody;
            priority if (cp_next < Utf8Lim1) begin
              res_o.cnt   = 2'd1;
              res_o.byte0 = cp_next[7:0];
            end else if (cp_next < Utf8Lim2) begin
              res_o.cnt   = 2'd2;
              res_o.byte0 = Utf8Lead2 | {3'b000, cp_next[10:6]};
              res_o.byte1 = Utf8Cont | {2'b00, cp_next[5:0] & Utf8Mask};
            end else begin
              res_o.cnt   = 2'd3;
              res_o.byte0 = Utf8Lead3 | {4'h0, cp_next[15:12]};
              res_o.byte1 = Utf8Cont | {2'b00, cp_next[11:6] & Utf8Mask};
              res_o.byte2 = Utf8Cont | {2'b00, cp_next[5:0] & Utf8Mask};
            end
          end
        end
      end
      default: begin
        // Waiting for an opening quote; the unused phase code behaves the same.
        phase_d = PhAwait;
        if (!end_mark_i && in_byte_i == ChQuote) begin
          phase_d = PhBody;
          cp_d    = 16'h0000;
        end else begin
          res_o.cnt  = 2'd1;
          res_o.kind = KindError;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhAwait;
      cp_q    <= 16'h0000;
    end else if (fire_i) begin
      phase_q <= phase_d;
      cp_q    <= cp_d;
    end
  end

endmodule

/* hw/rtl/json_string_unescape_top.sv */
// Top level of the streaming JSON string unescaper.
//
//   port   dir  word contents              meaning
//   in_i   in   in_byte[8], end_mark[1]    raw literal bytes, quotes included
//   out_o  out  out_byte[8], kind[2], last decoded byte, end or error marker
//
// An input word is decoded in the cycle it is accepted and its 0 to 3 results
// land in a result register, which hands them out one word per cycle while
// the output is ready. A \u escape that closes with two or three UTF-8 bytes
// holds the input until its last byte is taken. The next input word is taken
// in the same cycle as the last pending result. Reset puts the decoder in the
// wait for an opening quote and empties the result register. Output stalls
// hold the result register and the input.
`timescale 1ns / 1ps

module json_string_unescape_top
  import jsu_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  res_t       dec_res;
  res_t       res_q;
  logic       pend_q;
  logic [1:0] idx_q;
  logic       in_fire;
  logic       out_fire;
  logic       out_last;

  assign out_last = (idx_q == (res_q.cnt - 2'd1));
  assign out_fire = out_o.valid && out_o.ready;
  assign in_i.ready = !pend_q || (out_fire && out_last);
  assign in_fire  = in_i.valid && in_i.ready;

  jsu_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (in_fire),
    .in_byte_i  (in_i.in_byte),
    .end_mark_i (in_i.end_mark),
    .res_o      (dec_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      idx_q  <= 2'd0;
    end else begin
      if (in_fire && dec_res.cnt != 2'd0) begin
        pend_q <= 1'b1;
        idx_q  <= 2'd0;
      end else if (out_fire) begin
        if (out_last) begin
          pend_q <= 1'b0;
        end else begin
          idx_q <= idx_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire && dec_res.cnt != 2'd0) begin
      res_q <= dec_res;
    end
  end

  always_comb begin
    unique case (idx_q)
      2'd0:    out_o.out_byte = res_q.byte0;
      2'd1:    out_o.out_byte = res_q.byte1;
      default: out_o.out_byte = res_q.byte2;
    endcase
  end

  assign out_o.valid = pend_q;
  assign out_o.kind  = (idx_q == 2'd0) ? res_q.kind : KindByte;
  assign out_o.last  = out_last;

  // The read index never runs past the number of stored results.
  a_idx_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> (idx_q < res_q.cnt))
    else $error("result index beyond stored count");

  // An end or error result is always the only result of its word.
  a_marker_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KindByte) |-> (out_o.last && out_o.out_byte == 8'h00))
    else $error("end or error result is not a lone last word");

  // A result that is not the last one keeps the input closed.
  a_hold_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.last) |-> !in_i.ready)
    else $error("input taken while results still pending");

  // A taken non-last result is followed by the next result of the same word.
  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && !out_last) |=> (out_o.valid && idx_q == $past(idx_q) + 2'd1))
    else $error("result sequence did not advance");

endmodule

/* dv/jsu_result_checker.sv */
// Watches both channels of the unescaper, predicts every result word and compares.
`timescale 1ns / 1ps

module jsu_result_checker
  import jsu_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  jsu_in_if    in_i,
  jsu_out_if   out_i,
  output int   fail_count_o,
  output int   pending_o,
  output int   checked_o
);

  typedef enum logic [2:0] {
    PhAwait = 3'd0,
    PhBody  = 3'd1,
    PhEsc   = 3'd2,
    PhHex1  = 3'd3,
    PhHex2  = 3'd4,
    PhHex3  = 3'd5,
    PhHex4  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
  } result_t;

  result_t     decoded_q[$];
  phase_e      phase;
  logic [15:0] code_point;
  int          mismatches;

  assign fail_count_o = mismatches;

  task automatic report_mismatch(input string msg);
    $display("%0t ns mismatch: %s", $time, msg);
    mismatches++;
  endtask

  // Decodes one accepted input word and queues the result words it causes.
  function automatic void unescape_word(input logic [7:0] c, input logic ended);
    result_t    batch[$];
    logic [7:0] esc;
    logic       esc_ok;
    logic [7:0] digit;
    logic       hex_ok;
    batch = {};
    if (phase == PhAwait) begin
      if (!ended && c == ChQuote) begin
        phase = PhBody;
        code_point = '0;
      end else begin
        batch.push_back('{data: 8'h00, kind: KindError, last: 1'b0});
      end
    end else if (ended) begin
      batch.push_back('{data: 8'h00, kind: KindError, last: 1'b0});
      phase = PhAwait;
    end else begin
      case (phase)
        PhBody: begin
          if (c == ChQuote) begin
            batch.push_back('{data: 8'h00, kind: KindEnd, last: 1'b0});
            phase = PhAwait;
          end else if (c == ChBackslash) begin
            phase = PhEsc;
          end else begin
            batch.push_back('{data: c, kind: KindByte, last: 1'b0});
          end
        end
        PhEsc: begin
          esc_ok = 1'b1;
          esc = 8'h00;
          case (c)
            ChQuote, ChBackslash, ChSlash: esc = c;
            "n": esc = 8'h0A;
            "r": esc = 8'h0D;
            "t": esc = 8'h09;
            "b": esc = 8'h08;
            "f": esc = 8'h0C;
            default: esc_ok = 1'b0;
          endcase
          if (c == ChLowerU) begin
            code_point = '0;
            phase = PhHex1;
          end else if (esc_ok) begin
            batch.push_back('{data: esc, kind: KindByte, last: 1'b0});
            phase = PhBody;
          end else begin
            batch.push_back('{data: 8'h00, kind: KindError, last: 1'b0});
            phase = PhAwait;
          end
        end
        default: begin
          hex_ok = 1'b1;
          digit = 8'h00;
          if (c >= "0" && c <= "9") begin
            digit = c - "0";
          end else if (c >= "a" && c <= "f") begin
            digit = c - "a" + 8'd10;
          end else if (c >= "A" && c <= "F") begin
            digit = c - "A" + 8'd10;
          end else begin
            hex_ok = 1'b0;
          end
          if (!hex_ok) begin
            batch.push_back('{data: 8'h00, kind: KindError, last: 1'b0});
            phase = PhAwait;
          end else begin
            code_point = {code_point[11:0], digit[3:0]};
            if (phase != PhHex4) begin
              phase = phase_e'(phase + 3'd1);
            end else begin
              // The code point goes out as one, two or three UTF-8 bytes.
              if (code_point < Utf8Lim1) begin
                batch.push_back('{data: code_point[7:0], kind: KindByte, last: 1'b0});
              end else if (code_point < Utf8Lim2) begin
                batch.push_back('{data: Utf8Lead2 | {3'b000, code_point[10:6]},
                                  kind: KindByte, last: 1'b0});
                batch.push_back('{data: Utf8Cont | {2'b00, code_point[5:0] & Utf8Mask},
                                  kind: KindByte, last: 1'b0});
              end else begin
                batch.push_back('{data: Utf8Lead3 | {4'b0000, code_point[15:12]},
                                  kind: KindByte, last: 1'b0});
                batch.push_back('{data: Utf8Cont | {2'b00, code_point[11:6] & Utf8Mask},
                                  kind: KindByte, last: 1'b0});
                batch.push_back('{data: Utf8Cont | {2'b00, code_point[5:0] & Utf8Mask},
                                  kind: KindByte, last: 1'b0});
              end
              phase = PhBody;
            end
          end
        end
      endcase
    end
    if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
    foreach (batch[i]) decoded_q.push_back(batch[i]);
  endfunction

  initial begin
    mismatches = 0;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      phase = PhAwait;
      code_point = '0;
      decoded_q.delete();
      pending_o <= 0;
      checked_o <= 0;
    end else begin
      // Results of the word accepted at this edge cannot leave at the same edge.
      if (out_i.valid && out_i.ready) begin
        if (decoded_q.size() == 0) begin
          report_mismatch($sformatf(
              "result word byte %02h kind %0d last %0b with none expected",
              out_i.out_byte, out_i.kind, out_i.last));
        end else begin
          want = decoded_q.pop_front();
          if (out_i.out_byte !== want.data || out_i.kind !== want.kind ||
              out_i.last !== want.last) begin
            report_mismatch($sformatf(
                "got byte %02h kind %0d last %0b, want byte %02h kind %0d last %0b",
                out_i.out_byte, out_i.kind, out_i.last,
                want.data, want.kind, want.last));
          end
        end
        checked_o <= checked_o + 1;
      end
      if (in_i.valid && in_i.ready) unescape_word(in_i.in_byte, in_i.end_mark);
      pending_o <= decoded_q.size();
    end
  end

endmodule

/* dv/json_string_unescape_top_tb.sv */
// Testbench top of the JSON string unescaper: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module json_string_unescape_top_tb
  import jsu_pkg::*;
();

  localparam int IdleLimit = 500;
  localparam int WordTarget = 210;

  logic clk_i;
  logic rst_ni;
  int   fail_count;
  int   pending;
  int   checked;
  int   words_sent;
  int   good_literals;
  int   broken_literals;
  int   noise_runs;
  int   idle_cycles;
  bit   source_burst;
  bit   sink_burst;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  jsu_result_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_if),
    .out_i        (out_if),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .checked_o    (checked)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // Valid stays high from one word to the next when there is no gap between them.
  task automatic send_word(input logic [7:0] b, input logic ended);
    int gap;
    if ($urandom_range(0, 31) == 0) source_burst = !source_burst;
    gap = source_burst ? 0 : $urandom_range(0, 9);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= b;
    in_if.end_mark <= ended;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_word(s[i], 1'b0);
  endtask

  // Holds the input back until every predicted result word has been taken.
  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic send_hex_digit(input logic [3:0] v);
    logic [7:0] ch;
    if (v < 4'd10) ch = "0" + {4'h0, v};
    else ch = ($urandom_range(0, 1) ? "a" : "A") + {4'h0, v} - 8'd10;
    send_word(ch, 1'b0);
  endtask

  task automatic send_unicode_escape();
    logic [15:0] cp;
    case ($urandom_range(0, 2))
      0: cp = 16'($urandom_range(0, 'h7F));
      1: cp = 16'($urandom_range('h80, 'h7FF));
      default: cp = 16'($urandom_range('h800, 'hFFFF));
    endcase
    send_word(ChBackslash, 1'b0);
    send_word(ChLowerU, 1'b0);
    send_hex_digit(cp[15:12]);
    send_hex_digit(cp[11:8]);
    send_hex_digit(cp[7:4]);
    send_hex_digit(cp[3:0]);
  endtask

  // A quoted literal with random content; a broken one stops at a fault instead of closing.
  task automatic send_literal(input bit broken);
    int         parts;
    int         cut;
    int         good_digits;
    logic [7:0] b;
    parts = $urandom_range(1, 8);
    cut = $urandom_range(0, parts - 1);
    send_word(ChQuote, 1'b0);
    for (int i = 0; i < parts; i++) begin
      if (broken && i == cut) begin
        case ($urandom_range(0, 4))
          0: begin
            do b = 8'($urandom_range(0, 255));
            while (b == ChQuote || b == ChBackslash || b == ChSlash || b == ChLowerU ||
                   b == "n" || b == "r" || b == "t" || b == "b" || b == "f");
            send_word(ChBackslash, 1'b0);
            send_word(b, 1'b0);
          end
          1: begin
            good_digits = $urandom_range(0, 3);
            send_word(ChBackslash, 1'b0);
            send_word(ChLowerU, 1'b0);
            repeat (good_digits) send_hex_digit(4'($urandom_range(0, 15)));
            do b = 8'($urandom_range(0, 255));
            while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") ||
                   (b >= "A" && b <= "F"));
            send_word(b, 1'b0);
          end
          2: send_word(8'($urandom_range(0, 255)), 1'b1);
          3: begin
            send_word(ChBackslash, 1'b0);
            send_word(8'($urandom_range(0, 255)), 1'b1);
          end
          default: begin
            good_digits = $urandom_range(0, 3);
            send_word(ChBackslash, 1'b0);
            send_word(ChLowerU, 1'b0);
            repeat (good_digits) send_hex_digit(4'($urandom_range(0, 15)));
            send_word(8'($urandom_range(0, 255)), 1'b1);
          end
        endcase
        return;
      end
      case ($urandom_range(0, 5))
        4: begin
          send_word(ChBackslash, 1'b0);
          case ($urandom_range(0, 7))
            0: send_word(ChQuote, 1'b0);
            1: send_word(ChBackslash, 1'b0);
            2: send_word(ChSlash, 1'b0);
            3: send_word("n", 1'b0);
            4: send_word("r", 1'b0);
            5: send_word("t", 1'b0);
            6: send_word("b", 1'b0);
            default: send_word("f", 1'b0);
          endcase
        end
        5: send_unicode_escape();
        default: begin
          do b = 8'($urandom_range(0, 255));
          while (b == ChQuote || b == ChBackslash);
          send_word(b, 1'b0);
        end
      endcase
    end
    send_word(ChQuote, 1'b0);
  endtask

  // Result side: a random stall before each word, with stretches of none.
  initial begin
    int stall;
    out_if.ready = 1'b0;
    sink_burst = 1'b0;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 31) == 0) sink_burst = !sink_burst;
      stall = sink_burst ? 0 : $urandom_range(0, 9);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Timeout: no word moved for %0d cycles.", IdleLimit);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    int pick;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.in_byte = 8'h00;
    in_if.end_mark = 1'b0;
    idle_cycles = 0;
    words_sent = 0;
    good_literals = 0;
    broken_literals = 0;
    noise_runs = 0;
    source_burst = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: missing opening quote, end of data while waiting, extreme
    // bytes, two- and three-byte code points, bad escape, bad hex digit and
    // end of data inside the string.
    send_text("a");
    send_word(8'h00, 1'b1);
    send_text("\"");
    send_word(8'hFF, 1'b0);
    send_text("\\u07fF\\uFFFF\"");
    send_text("\"\\q");
    send_text("\"\\ug");
    send_text("\"");
    send_word(8'hFF, 1'b1);
    drain();

    while (words_sent < WordTarget) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_literal(1'b0);
        good_literals++;
      end else if (pick < 9) begin
        send_literal(1'b1);
        broken_literals++;
      end else begin
        repeat ($urandom_range(1, 4)) begin
          send_word(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        noise_runs++;
      end
      if ($urandom_range(0, 14) == 0) drain();
    end

    drain();
    repeat (10) @(posedge clk_i);

    $display("Sent %0d input words: %0d clean literals, %0d broken literals, %0d noise runs.",
             words_sent, good_literals, broken_literals, noise_runs);
    $display("Checked %0d result words under random gaps and stalls.", checked);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

/* json_string_unescape_top.f */
hw/rtl/jsu_pkg.sv
hw/rtl/jsu_if.sv
hw/rtl/jsu_decode.sv
hw/rtl/json_string_unescape_top.sv
dv/jsu_result_checker.sv
dv/json_string_unescape_top_tb.sv
